// ===== design/assert_macros.svh =====
// Assertion macros for the design files; sdse_back includes them.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property violated");

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== design/sdse_pkg.sv =====
package sdse_pkg;

   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;

   // Request function codes.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int TERM_LEN = 5;
   // Close of an unterminated line followed by the dot terminator.
   localparam logic [7:0] TERM_SEQ [TERM_LEN] = '{CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF};

   typedef logic [2:0] step_type;

   // What the back end has to emit for one accepted item.
   typedef enum logic [2:0] {
      KIND_PLAIN      = 3'd0,  // the byte itself
      KIND_DOT_BYTE   = 3'd1,  // stuffed dot, then the byte
      KIND_CRLF       = 3'd2,  // normalized line end
      KIND_TERM       = 3'd3,  // dot CR LF
      KIND_CLOSE_TERM = 3'd4   // CR LF dot CR LF
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } cmd_type;

   // Front end to queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic step_type run_len(kind_type kind);
      step_type len;
      unique case (kind)
         KIND_PLAIN:      len = 3'd1;
         KIND_DOT_BYTE:   len = 3'd2;
         KIND_CRLF:       len = 3'd2;
         KIND_TERM:       len = 3'd3;
         KIND_CLOSE_TERM: len = 3'd5;
         default:         len = 3'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] seq_byte(cmd_type cmd, step_type step);
      logic [7:0] b;
      unique case (cmd.kind)
         KIND_PLAIN:      b = cmd.data;
         KIND_DOT_BYTE:   b = (step == 3'd0) ? CH_DOT : cmd.data;
         KIND_CRLF:       b = (step == 3'd0) ? CH_CR : CH_LF;
         KIND_TERM:       b = TERM_SEQ[step + 3'd2];
         KIND_CLOSE_TERM: b = TERM_SEQ[step];
         default:         b = cmd.data;
      endcase
      return b;
   endfunction

endpackage

// ===== design/sdse_ifs.sv =====
interface sdse_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;

   modport source (output valid, func, data_byte, input ready);
   modport sink   (input valid, func, data_byte, output ready);
endinterface

interface sdse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       message_done;

   modport source (output valid, out_byte, last_of_run, message_done, input ready);
   modport sink   (input valid, out_byte, last_of_run, message_done, output ready);
endinterface

// ===== design/sdse_front.sv =====
module sdse_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_func,
   input  logic [7:0]         in_data,
   output logic               in_ready,
   input  logic               q_full,
   output sdse_pkg::push_type push
);
   import sdse_pkg::*;

   logic at_line_start_ff, at_line_start_in;
   logic after_cr_ff, after_cr_in;
   logic accept;
   logic is_eol;
   push_type item;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign is_eol   = (in_data == CH_CR) || (in_data == CH_LF);

   always_comb begin
      item.valid    = 1'b1;
      item.cmd.data = in_data;
      item.cmd.kind = KIND_PLAIN;
      at_line_start_in = at_line_start_ff;
      after_cr_in      = 1'b0;
      priority if (in_func == FUNC_END) begin
         item.cmd.kind    = at_line_start_ff ? KIND_TERM : KIND_CLOSE_TERM;
         at_line_start_in = 1'b1;
      end else if (after_cr_ff && in_data == CH_LF) begin
         // The LF completes the line end already sent for the CR.
         item.valid = 1'b0;
      end else if (is_eol) begin
         item.cmd.kind    = KIND_CRLF;
         at_line_start_in = 1'b1;
         after_cr_in      = (in_data == CH_CR);
      end else begin
         item.cmd.kind    = (at_line_start_ff && in_data == CH_DOT) ? KIND_DOT_BYTE : KIND_PLAIN;
         at_line_start_in = 1'b0;
      end
   end

   always_comb begin
      push       = item;
      push.valid = accept && item.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         after_cr_ff      <= 1'b0;
      end else if (accept) begin
         at_line_start_ff <= at_line_start_in;
         after_cr_ff      <= after_cr_in;
      end
   end

endmodule

// ===== design/sdse_queue.sv =====
module sdse_queue #(
   parameter int Depth = sdse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  sdse_pkg::push_type push,
   output logic               full,
   output sdse_pkg::head_type head,
   input  logic               pop
);
   import sdse_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type         entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

// ===== design/sdse_back.sv =====
module sdse_back (
   input  logic               clock,
   input  logic               reset,
   input  sdse_pkg::head_type head,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_last,
   output logic               out_done
);
   import sdse_pkg::*;

   `include "assert_macros.svh"

   step_type   step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, done_ff;
   logic       load;
   logic       step_last;
   logic       is_term;

   assign load      = head.valid && (!valid_ff || out_ready);
   assign step_last = (step_ff == run_len(head.cmd.kind) - 3'd1);
   assign is_term   = (head.cmd.kind == KIND_TERM) || (head.cmd.kind == KIND_CLOSE_TERM);
   assign pop       = load && step_last;

   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = '0;
      end else if (load) begin
         step_in = step_ff + 3'd1;
      end
      valid_in = load ? 1'b1 : (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= seq_byte(head.cmd, step_ff);
         last_ff <= step_last;
         done_ff <= step_last && is_term;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_done  = done_ff;

   `ASSERT_PROP(a_done_on_final_lf, clock, reset, (valid_ff && done_ff) |-> (last_ff && byte_ff == CH_LF))
   `ASSERT_NEVER(a_step_in_range, clock, reset, head.valid && step_ff >= run_len(head.cmd.kind))
   `ASSERT_PROP(a_pop_marks_last, clock, reset, pop |=> (valid_ff && last_ff))

endmodule

// ===== design/smtp_dot_stuffing_encoder.sv =====
// SMTP dot-stuffing encoder. Each request transfer carries one body byte
// (func = 0) or an end-of-message mark (func = 1); the response channel
// carries the wire stream one byte per transfer. Lone CR, lone LF and
// CR LF all leave as CR LF, a dot at the start of a line is doubled, and
// end of message closes an open line with CR LF and then sends dot CR LF,
// flagging the final LF with message_done. last_of_run marks the last
// byte caused by each request. Rate: the back end's byte sequencer sends
// one byte per cycle while the receiver is ready; a request yields one
// byte for an ordinary byte, two for a line end or a stuffed dot, three
// or five for end of message, and none for the LF of a CR LF pair; the
// front end takes a request every cycle while the command queue has room.
// A request passes through the command queue and the registered response
// stage before its first byte is presented.
module smtp_dot_stuffing_encoder #(
   parameter int QUEUE_DEPTH = sdse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   sdse_req_if.sink   req_chan,
   sdse_rsp_if.source rsp_chan
);
   import sdse_pkg::*;

   // Front end: classifies each request and tracks line state.
   push_type push;
   head_type head;
   logic     q_full;
   logic     pop;

   sdse_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_func  (req_chan.func),
      .in_data  (req_chan.data_byte),
      .in_ready (req_chan.ready),
      .q_full   (q_full),
      .push     (push)
   );

   // Command queue: lets the front keep taking requests while the back
   // end is busy with a multi-byte run or the response side stalls.
   sdse_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // Back end: steps through the bytes of each command into the
   // registered response stage.
   sdse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_byte  (rsp_chan.out_byte),
      .out_last  (rsp_chan.last_of_run),
      .out_done  (rsp_chan.message_done)
   );

endmodule

// ===== verif/tb_smtp_dot_stuffing_encoder.sv =====
`timescale 1ns / 1ps

module tb_smtp_dot_stuffing_encoder;
   import sdse_pkg::*;

   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int unsigned STALL_LIMIT = 2000;
   // Cycles allowed after the last expected byte.
   localparam int unsigned TAIL_CYCLES = 20;
   // Length of the long receiver hold-off.
   localparam int unsigned LONG_HOLD = 80;
   localparam int unsigned RANDOM_ITEMS = 200;

   // One byte of the wire stream together with its flags.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       message_done;
   } wire_byte_type;

   // Tracks the line state of the encoder and keeps the wire bytes still owed by it.
   class scoreboard_type;
      wire_byte_type owed_bytes[$];
      bit            line_start;
      bit            pending_cr;
      int unsigned   errors;

      function new();
         line_start = 1'b1;
         pending_cr = 1'b0;
         errors     = 0;
      endfunction

      function void owe(logic [7:0] b, logic last, logic done);
         wire_byte_type w;
         w.out_byte     = b;
         w.last_of_run  = last;
         w.message_done = done;
         owed_bytes.push_back(w);
      endfunction

      // Works out the wire bytes that one accepted request causes.
      function void note_request(logic fn, logic [7:0] b);
         if (fn == FUNC_END) begin
            // An open line is closed before the terminator.
            if (!line_start) begin
               owe(CH_CR, 1'b0, 1'b0);
               owe(CH_LF, 1'b0, 1'b0);
            end
            owe(CH_DOT, 1'b0, 1'b0);
            owe(CH_CR, 1'b0, 1'b0);
            owe(CH_LF, 1'b1, 1'b1);
            line_start = 1'b1;
            pending_cr = 1'b0;
         end else if (pending_cr && b == CH_LF) begin
            // The LF of a CR LF pair was already sent along with the CR.
            pending_cr = 1'b0;
         end else if (b == CH_CR || b == CH_LF) begin
            owe(CH_CR, 1'b0, 1'b0);
            owe(CH_LF, 1'b1, 1'b0);
            line_start = 1'b1;
            pending_cr = (b == CH_CR);
         end else begin
            if (line_start && b == CH_DOT) owe(CH_DOT, 1'b0, 1'b0);
            owe(b, 1'b1, 1'b0);
            line_start = 1'b0;
            pending_cr = 1'b0;
         end
      endfunction

      // Compares one accepted wire byte with the oldest one owed.
      function void check_response(logic [7:0] b, logic last, logic done);
         wire_byte_type w;
         if (owed_bytes.size() == 0) begin
            $display("%0t ns: unexpected byte, expected none, actual %02h last %0b done %0b",
                     $time, b, last, done);
            errors++;
            return;
         end
         w = owed_bytes.pop_front();
         if (b !== w.out_byte) begin
            $display("%0t ns: out_byte mismatch, expected %02h, actual %02h",
                     $time, w.out_byte, b);
            errors++;
         end
         if (last !== w.last_of_run) begin
            $display("%0t ns: last_of_run mismatch, expected %0b, actual %0b",
                     $time, w.last_of_run, last);
            errors++;
         end
         if (done !== w.message_done) begin
            $display("%0t ns: message_done mismatch, expected %0b, actual %0b",
                     $time, w.message_done, done);
            errors++;
         end
      endfunction

      function int pending();
         return owed_bytes.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sdse_req_if req_if ();
   sdse_rsp_if rsp_if ();

   smtp_dot_stuffing_encoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   scoreboard_type board;

   // When set, both sides run without idle cycles.
   bit          quiet;
   // Set by the stimulus to ask the receiver for a long hold-off of this many cycles.
   int unsigned hold_request;
   int unsigned items_sent;
   int unsigned idle_cycles;

   initial begin
      clock = 1'b0;
   end

   always #2 clock = ~clock;

   // Transfers are observed at the rising edge, before the design updates its registers.
   // Each request is turned into owed bytes first; a byte arriving at the same edge
   // always belongs to an earlier request, so the order within the block is harmless.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            board.note_request(req_if.func, req_if.data_byte);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            board.check_response(rsp_if.out_byte, rsp_if.last_of_run, rsp_if.message_done);
         end
      end
   end

   // Watchdog: ends the run when neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver. Before every byte it draws a random stall with ready low,
   // then holds ready high until a transfer happens. When the stimulus asks for a
   // long hold-off, ready stays low for that many cycles, counted here.
   initial begin
      int unsigned stall;
      int unsigned hold;
      rsp_if.ready = 1'b0;
      forever begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end else begin
            stall = quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
               @(negedge clock);
               rsp_if.ready <= 1'b0;
               repeat (stall - 1) @(negedge clock);
            end
            @(negedge clock);
            rsp_if.ready <= 1'b1;
            // Wait for a transfer; a hold-off request also ends the wait.
            do @(posedge clock); while (!rsp_if.valid && hold_request == 0);
         end
      end
   end

   // Offers one request after a random gap and waits for it to be taken.
   // Valid is only lowered at a falling edge where it will not be raised again.
   task automatic send_item(input logic fn, input logic [7:0] b);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.func      <= fn;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Drops valid and waits until every owed byte has come out.
   task automatic wait_for_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned msg_len;
      int unsigned msg_index;
      logic [7:0]  b;
      bit          pressure_done;
      bit          pause_done;

      board = new();
      quiet = 1'b0;
      hold_request = 0;
      items_sent = 0;
      pressure_done = 1'b0;
      pause_done = 1'b0;
      msg_index = 0;

      req_if.valid     = 1'b0;
      req_if.func      = FUNC_BYTE;
      req_if.data_byte = 8'h00;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. An empty message comes first, with data on the end mark
      // that the block must ignore.
      send_item(FUNC_END, 8'hFF);
      // A dot opening a line is doubled; one in the middle of a line is not.
      send_item(FUNC_BYTE, CH_DOT);
      send_item(FUNC_BYTE, "a");
      send_item(FUNC_BYTE, CH_DOT);
      // CR LF is one line end, and the dot after it is doubled again.
      send_item(FUNC_BYTE, CH_CR);
      send_item(FUNC_BYTE, CH_LF);
      send_item(FUNC_BYTE, CH_DOT);
      send_item(FUNC_BYTE, CH_DOT);
      // Lone CR and lone LF each become CR LF.
      send_item(FUNC_BYTE, CH_CR);
      send_item(FUNC_BYTE, "x");
      send_item(FUNC_BYTE, CH_LF);
      // CR CR is two line ends; an LF after a paired LF is a line end of its own.
      send_item(FUNC_BYTE, CH_CR);
      send_item(FUNC_BYTE, CH_CR);
      send_item(FUNC_BYTE, CH_LF);
      send_item(FUNC_BYTE, CH_LF);
      // Extreme byte values, then an end mark that has to close the open line.
      send_item(FUNC_BYTE, 8'h00);
      send_item(FUNC_BYTE, 8'hFF);
      send_item(FUNC_END, CH_CR);
      // A body ending in a line end gets no extra CR LF; the end mark also forgets
      // the pending CR, so the LF that follows starts a line end of its own.
      send_item(FUNC_BYTE, CH_CR);
      send_item(FUNC_END, CH_LF);
      send_item(FUNC_BYTE, CH_LF);
      send_item(FUNC_END, 8'h00);

      // Random part: whole messages with random bodies, each closed by an end mark.
      // Line ends and dots are drawn often so that stuffing and pairing are busy.
      while (items_sent < RANDOM_ITEMS + 22) begin
         quiet = (msg_index % 7 == 3);

         // Long receiver hold-off while the sender keeps offering, so the
         // command queue fills and the request side stalls.
         if (!pressure_done && items_sent >= 70) begin
            pressure_done = 1'b1;
            quiet = 1'b1;
            hold_request = LONG_HOLD;
         end

         // Sender pause until the encoder has delivered everything.
         if (!pause_done && items_sent >= 150) begin
            pause_done = 1'b1;
            wait_for_drain();
         end

         msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 12);
         repeat (msg_len) begin
            case ($urandom_range(0, 9))
               0, 1:    b = CH_DOT;
               2:       b = CH_CR;
               3:       b = CH_LF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            send_item(FUNC_BYTE, b);
         end
         send_item(FUNC_END, 8'($urandom_range(0, 255)));
         msg_index++;
      end

      quiet = 1'b0;
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (board.pending() != 0) begin
            $display("%0t ns: %0d expected bytes never arrived", $time, board.pending());
         end
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/sdse_pkg.sv
design/sdse_ifs.sv
design/sdse_front.sv
design/sdse_queue.sv
design/sdse_back.sv
design/smtp_dot_stuffing_encoder.sv
verif/tb_smtp_dot_stuffing_encoder.sv
